### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OVL_ASSERT_IMPLY(label, clk, rst, ant, con) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define OVL_ASSERT_NEXT(label, clk, rst, ant, con) \
   label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
      else $error("next-cycle implication failed");

`endif

### hw/rtl/ovl_pkg.sv
// Types, codes and sizes shared by the ordered value list engine.
package ovl_pkg;

   localparam int Depth = 64;
   localparam int IdxWidth = $clog2(Depth);
   localparam int ValueWidth = 32;
   localparam int CountWidth = 7;
   localparam logic [CountWidth-1:0] CountDepth = CountWidth'(Depth);

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_PURGE  = 3'd2;
   localparam logic [2:0] CMD_MOVE   = 3'd3;
   localparam logic [2:0] CMD_DUMP   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_ANCHOR = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [2:0]                   cmd;
      logic signed [ValueWidth-1:0] key;
      logic signed [ValueWidth-1:0] val;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] item_value;
      logic [1:0]                   status;
      logic [CountWidth-1:0]        entry_total;
      logic                         last;
   } rsp_type;

   typedef struct packed {
      logic eq;
      logic le;
   } cmp_result_type;

endpackage

### hw/rtl/ovl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ovl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ovl_cmp.sv
// Shared compare unit: equality and signed at-or-below test of an entry.
module ovl_cmp (
   input  logic signed [ovl_pkg::ValueWidth-1:0] entry,
   input  logic signed [ovl_pkg::ValueWidth-1:0] ref_value,
   output ovl_pkg::cmp_result_type               result
);

   always_comb begin
      result.eq = (entry == ref_value);
      result.le = (entry <= ref_value);
   end

endmodule

### hw/rtl/ordered_value_list_engine.sv
// Ordered value list engine: top level with command sequencer.
//
// Usage: one command enters on the req_ channel (cmd, key, val) as a
// valid/ready transfer. The block keeps up to 64 signed 32-bit entries in a
// RAM and works through them one entry at a time with a single compare unit.
// Each visited entry takes a RAM read step, then a compare or write step.
// Append and unused codes finish without a pass over the entries; insert
// searches for its anchor, then shifts the entries behind it; purge makes
// one pass; move makes up to four such passes. Dump streams every entry,
// one rsp_ transfer each with last on the final one, then leaves the list
// empty. Every other command gives exactly one rsp_ transfer with last set.
// req_ready is high only while no command is in progress. The result sits
// in an output register, so the next command is taken while it waits; a
// stalled receiver holds the result and stops the sequencer at its next
// result. Reset empties the list at once: the entry count is cleared and no
// RAM clearing pass is run.
module ordered_value_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ovl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ovl_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      IDLE,
      FIND_RD,
      FIND_CHK,
      SHIFT_RD,
      SHIFT_WR,
      PUT,
      CMP_RD,
      CMP_CHK,
      RESP,
      DUMP_RD,
      DUMP_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cmd_ff, cmd_in;
   logic signed [ovl_pkg::ValueWidth-1:0] key_ff, key_in;
   logic signed [ovl_pkg::ValueWidth-1:0] val_ff, val_in;
   logic [ovl_pkg::CountWidth-1:0] count_ff, count_in;
   logic [ovl_pkg::CountWidth-1:0] ptr_ff, ptr_in;
   logic [ovl_pkg::CountWidth-1:0] wptr_ff, wptr_in;
   logic [ovl_pkg::CountWidth-1:0] pos_ff, pos_in;
   logic [1:0] status_ff, status_in;
   logic move2_ff, move2_in;
   logic rsp_valid_ff, rsp_valid_in;
   ovl_pkg::rsp_type rsp_ff, rsp_in;

   logic mem_wr_en;
   logic [ovl_pkg::IdxWidth-1:0] mem_wr_addr;
   logic [ovl_pkg::ValueWidth-1:0] mem_wr_data;
   logic mem_rd_en;
   logic [ovl_pkg::IdxWidth-1:0] mem_rd_addr;
   logic [ovl_pkg::ValueWidth-1:0] mem_rd_data;

   logic signed [ovl_pkg::ValueWidth-1:0] cmp_ref;
   ovl_pkg::cmp_result_type cmp_res;

   logic out_free;
   logic [ovl_pkg::CountWidth-1:0] ptr_dec;
   logic [ovl_pkg::CountWidth-1:0] ptr_inc;
   logic [ovl_pkg::CountWidth-1:0] pos_next;
   logic drop;

   ovl_ram #(
      .WIDTH(ovl_pkg::ValueWidth),
      .DEPTH(ovl_pkg::Depth)
   ) u_ovl_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // move searches for its anchor in val; everything else compares with key
   assign cmp_ref = (cmd_ff == ovl_pkg::CMD_MOVE && state_ff == FIND_CHK) ? val_ff : key_ff;

   ovl_cmp u_ovl_cmp (
      .entry     (mem_rd_data),
      .ref_value (cmp_ref),
      .result    (cmp_res)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ptr_dec  = ptr_ff - 1'b1;
   assign ptr_inc  = ptr_ff + 1'b1;
   assign pos_next = pos_ff + 1'b1;
   assign drop     = (cmd_ff == ovl_pkg::CMD_PURGE) ? cmp_res.le : cmp_res.eq;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      wptr_in      = wptr_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      move2_in     = move2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ptr_ff[ovl_pkg::IdxWidth-1:0];
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = ptr_ff[ovl_pkg::IdxWidth-1:0];

      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.cmd;
               key_in    = req_data.key;
               val_in    = req_data.val;
               ptr_in    = '0;
               wptr_in   = '0;
               move2_in  = 1'b0;
               status_in = ovl_pkg::ST_OK;
               unique case (req_data.cmd) inside
                  ovl_pkg::CMD_APPEND: begin
                     if (count_ff >= ovl_pkg::CountDepth) begin
                        status_in = ovl_pkg::ST_FULL;
                        state_in  = RESP;
                     end else begin
                        ptr_in   = count_ff;
                        state_in = PUT;
                     end
                  end
                  ovl_pkg::CMD_INSERT, ovl_pkg::CMD_MOVE: begin
                     state_in = FIND_RD;
                  end
                  ovl_pkg::CMD_PURGE: begin
                     state_in = CMP_RD;
                  end
                  ovl_pkg::CMD_DUMP: begin
                     if (count_ff == '0) begin
                        status_in = ovl_pkg::ST_EMPTY;
                        state_in  = RESP;
                     end else begin
                        // wptr holds the number of entries to stream
                        wptr_in  = count_ff;
                        count_in = '0;
                        state_in = DUMP_RD;
                     end
                  end
                  default: begin
                     state_in = RESP;
                  end
               endcase
            end
         end

         FIND_RD: begin
            if (ptr_ff >= count_ff) begin
               // after the copies of a move are gone, a missing anchor is fine
               status_in = (cmd_ff == ovl_pkg::CMD_MOVE && move2_ff) ?
                           ovl_pkg::ST_OK : ovl_pkg::ST_NO_ANCHOR;
               state_in  = RESP;
            end else begin
               mem_rd_en = 1'b1;
               state_in  = FIND_CHK;
            end
         end

         FIND_CHK: begin
            if (cmp_res.eq) begin
               if (cmd_ff == ovl_pkg::CMD_MOVE && !move2_ff) begin
                  ptr_in   = '0;
                  wptr_in  = '0;
                  state_in = CMP_RD;
               end else if (count_ff >= ovl_pkg::CountDepth) begin
                  status_in = ovl_pkg::ST_FULL;
                  state_in  = RESP;
               end else begin
                  pos_in   = ptr_ff;
                  ptr_in   = count_ff;
                  state_in = SHIFT_RD;
               end
            end else begin
               ptr_in   = ptr_inc;
               state_in = FIND_RD;
            end
         end

         SHIFT_RD: begin
            if (ptr_ff > pos_next) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_dec[ovl_pkg::IdxWidth-1:0];
               state_in    = SHIFT_WR;
            end else begin
               state_in = PUT;
            end
         end

         SHIFT_WR: begin
            mem_wr_en = 1'b1;
            ptr_in    = ptr_dec;
            state_in  = SHIFT_RD;
         end

         PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (cmd_ff == ovl_pkg::CMD_MOVE) ? key_ff : val_ff;
            count_in    = count_ff + 1'b1;
            state_in    = RESP;
         end

         CMP_RD: begin
            if (ptr_ff >= count_ff) begin
               count_in = wptr_ff;
               if (cmd_ff == ovl_pkg::CMD_MOVE) begin
                  move2_in = 1'b1;
                  ptr_in   = '0;
                  state_in = FIND_RD;
               end else begin
                  state_in = RESP;
               end
            end else begin
               mem_rd_en = 1'b1;
               state_in  = CMP_CHK;
            end
         end

         CMP_CHK: begin
            // keep the entry: write it back at the compacted position
            if (!drop) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wptr_ff[ovl_pkg::IdxWidth-1:0];
               wptr_in     = wptr_ff + 1'b1;
            end
            ptr_in   = ptr_inc;
            state_in = CMP_RD;
         end

         RESP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.item_value  = '0;
               rsp_in.status      = status_ff;
               rsp_in.entry_total = count_ff;
               rsp_in.last        = 1'b1;
               state_in           = IDLE;
            end
         end

         DUMP_RD: begin
            mem_rd_en = 1'b1;
            state_in  = DUMP_OUT;
         end

         DUMP_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.item_value  = mem_rd_data;
               rsp_in.status      = ovl_pkg::ST_OK;
               rsp_in.entry_total = '0;
               rsp_in.last        = (ptr_inc == wptr_ff);
               ptr_in             = ptr_inc;
               state_in           = (ptr_inc == wptr_ff) ? IDLE : DUMP_RD;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         move2_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         move2_ff     <= move2_in;
      end
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      wptr_ff   <= wptr_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

endmodule

### hw/rtl/ovl_checker.sv
// Port-level checker for the ordered value list engine, bound to the top level.
`include "assert_macros.svh"

module ovl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ovl_pkg::rsp_type rsp_data
);

   logic req_xfer;
   logic rsp_stall;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled result must hold
   `OVL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // every command keeps the sequencer busy in the cycle after it is taken
   `OVL_ASSERT_NEXT(a_busy_after_req, clock, reset, req_xfer, !req_ready)

   // only a dump streams results before the last, and those show an empty list
   `OVL_ASSERT_IMPLY(a_stream_shape, clock, reset, rsp_valid && !rsp_data.last,
      rsp_data.status == ovl_pkg::ST_OK && rsp_data.entry_total == '0)

   // an empty dump is a single zero result
   `OVL_ASSERT_IMPLY(a_empty_dump, clock, reset,
      rsp_valid && rsp_data.status == ovl_pkg::ST_EMPTY,
      rsp_data.last && rsp_data.entry_total == '0 && rsp_data.item_value == '0)

   // the list never reports more entries than it can hold
   `OVL_ASSERT_IMPLY(a_total_bound, clock, reset, rsp_valid,
      rsp_data.entry_total <= ovl_pkg::CountDepth)

endmodule

bind ordered_value_list_engine ovl_checker u_ovl_checker (.*);
